// File: rtl/core/shell_syntax_dfa_checker_defines.svh
// Assertion macros for the shell syntax checker.
// Expect clk and rst_n in scope at the point of use.
`ifndef SHELL_SYNTAX_DFA_CHECKER_DEFINES_SVH
`define SHELL_SYNTAX_DFA_CHECKER_DEFINES_SVH

// Implication in the same cycle.
`define SSDFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define SSDFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ssdfa_pkg.sv
// Shared types, constants and the transition table of the shell syntax checker.
// No dependencies.
package ssdfa_pkg;

    localparam int NUM_STATES  = 13;
    localparam int NUM_CLASSES = 9;

    typedef logic [3:0] dfa_state_t;

    localparam dfa_state_t ST_START   = 4'd0;
    localparam dfa_state_t ST_WORD    = 4'd1;
    localparam dfa_state_t ST_SPACE   = 4'd5;
    localparam dfa_state_t ST_ERR     = 4'd9;
    localparam dfa_state_t ST_HEREDOC = 4'd11;

    typedef enum logic [3:0] {
        CLS_WORD   = 4'd0,
        CLS_PIPE   = 4'd1,
        CLS_LT     = 4'd2,
        CLS_GT     = 4'd3,
        CLS_SPACE  = 4'd4,
        CLS_DOLLAR = 4'd5,
        CLS_DQUOTE = 4'd6,
        CLS_SQUOTE = 4'd7,
        CLS_OTHER  = 4'd8
    } char_class_t;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_HEREDOC = 2'd1,
        VERDICT_ERROR   = 2'd2
    } verdict_t;

    typedef struct packed {
        verdict_t   verdict;
        dfa_state_t final_state;
    } result_t;

    localparam dfa_state_t NEXT_TBL [NUM_STATES][NUM_CLASSES] = '{
        '{4'd1, 4'd9, 4'd3,  4'd4,  4'd5,  4'd1, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd2, 4'd3,  4'd4,  4'd5,  4'd6, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd9, 4'd3,  4'd4,  4'd5,  4'd6, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd9, 4'd11, 4'd9,  4'd12, 4'd6, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd2, 4'd9,  4'd10, 4'd12, 4'd6, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd2, 4'd3,  4'd4,  4'd5,  4'd6, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd9, 4'd9,  4'd9,  4'd5,  4'd9, 4'd9, 4'd9, 4'd1},
        '{4'd7, 4'd7, 4'd7,  4'd7,  4'd7,  4'd7, 4'd5, 4'd7, 4'd7},
        '{4'd8, 4'd8, 4'd8,  4'd8,  4'd8,  4'd8, 4'd8, 4'd5, 4'd8},
        '{4'd9, 4'd9, 4'd9,  4'd9,  4'd9,  4'd9, 4'd9, 4'd9, 4'd1},
        '{4'd1, 4'd9, 4'd9,  4'd9,  4'd12, 4'd9, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd9, 4'd9,  4'd9,  4'd12, 4'd9, 4'd7, 4'd8, 4'd1},
        '{4'd1, 4'd9, 4'd9,  4'd9,  4'd12, 4'd6, 4'd7, 4'd8, 4'd1}
    };

    // Out-of-range states fall into the error state.
    function automatic dfa_state_t dfa_next(dfa_state_t s, char_class_t c);
        dfa_state_t ns;
        if (s < dfa_state_t'(NUM_STATES))
        begin
            ns = NEXT_TBL[s][c];
        end
        else
        begin
            ns = ST_ERR;
        end
        return ns;
    endfunction

endpackage

// File: rtl/core/ssdfa_if.sv
// Valid/ready channel interfaces for characters in and verdicts out.
// Depends on ssdfa_pkg.
interface ssdfa_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output byte_in, output last, input ready);
    modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface ssdfa_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [3:0] final_state;

    modport source (output valid, output verdict, output final_state, input ready);
    modport sink   (input valid, input verdict, input final_state, output ready);
endinterface

// File: rtl/core/ssdfa_classify.sv
// Character class decoder: sorts one byte into one of eight of the nine classes (never CLS_DOLLAR).
// Depends on ssdfa_pkg.
module ssdfa_classify
    import ssdfa_pkg::*;
(
    input  logic [7:0]  byte_in,
    output char_class_t cls
);

    always_comb
    begin
        unique case (byte_in) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
            8'h00, 8'h5F, 8'h2F, 8'h7E, 8'h5B, 8'h5D, 8'h2A, 8'h2B,
            8'h24, 8'h2C, 8'h2E, 8'h2D, 8'h3A, 8'h21, 8'h5C, 8'h25,
            8'h28, 8'h29, 8'h3D, 8'h3F, 8'h7D, 8'h7B, 8'h3B:
                cls = CLS_WORD;
            8'h7C:              cls = CLS_PIPE;
            8'h3C:              cls = CLS_LT;
            8'h3E:              cls = CLS_GT;
            8'h22:              cls = CLS_DQUOTE;
            8'h27:              cls = CLS_SQUOTE;
            [8'h09:8'h0F], 8'h20: cls = CLS_SPACE;
            default:            cls = CLS_OTHER;
        endcase
    end

endmodule

// File: rtl/core/ssdfa_core.sv
// Automaton state, sticky error and here-document marks, and verdict logic.
// Depends on ssdfa_pkg.
module ssdfa_core
    import ssdfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  char_class_t cls,
    input  logic        last,
    output result_t     res
);

    dfa_state_t state_reg, state_next;
    logic       err_reg, err_next;
    logic       hd_reg, hd_next;
    dfa_state_t tbl_state;

    assign tbl_state = dfa_next(state_reg, cls);

    always_comb
    begin
        // hold everything once an error has been seen
        if (err_reg)
        begin
            state_next = state_reg;
            err_next   = 1'b1;
            hd_next    = hd_reg;
        end
        else
        begin
            state_next = tbl_state;
            err_next   = (tbl_state == ST_ERR);
            hd_next    = hd_reg | (tbl_state == ST_HEREDOC);
        end

        res.final_state = state_next;
        if (err_next)
        begin
            res.verdict = VERDICT_ERROR;
        end
        else if (hd_next && state_next != ST_HEREDOC)
        begin
            res.verdict = VERDICT_HEREDOC;
        end
        else if (state_next == ST_WORD || state_next == ST_SPACE)
        begin
            res.verdict = VERDICT_OK;
        end
        else
        begin
            res.verdict = VERDICT_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            err_reg   <= 1'b0;
            hd_reg    <= 1'b0;
        end
        else if (step)
        begin
            // drop all line state after the last character
            if (last)
            begin
                state_reg <= ST_START;
                err_reg   <= 1'b0;
                hd_reg    <= 1'b0;
            end
            else
            begin
                state_reg <= state_next;
                err_reg   <= err_next;
                hd_reg    <= hd_next;
            end
        end
    end

endmodule

// File: rtl/core/shell_syntax_dfa_checker.sv
// Shell command-line syntax checker, top level.
// Depends on ssdfa_pkg, ssdfa_if, ssdfa_classify, ssdfa_core and the defines header.
//
// Usage: send the characters of one command line on char_ch, one byte per
// transfer, with last set on the final character (no terminator). Each line
// yields exactly one transfer on result_ch: verdict (0 accepted, 1 accepted
// with here-document, 2 syntax error) and the automaton's final state.
// Bytes that are not last produce nothing.
// Result path: class decode feeds the input register at the transfer edge of
// the last byte, and one table step fills the result register when that byte
// leaves the input register; the result is then offered on result_ch.
// Throughput: one byte per cycle, set by the table lookup that updates the
// automaton state, unless a last byte waits for the result register.
// Stall: a waiting result does not block bytes that are not last; the input
// register holds a last byte, with char_ch.ready low, until the result
// register is free.
// Reset: rst_n clears the automaton to its start state, both marks, and
// both valid flags; no result is pending after reset.
`include "shell_syntax_dfa_checker_defines.svh"

module shell_syntax_dfa_checker
    import ssdfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ssdfa_char_if.sink            char_ch,
    ssdfa_result_if.source        result_ch
);

    char_class_t cls_dec;
    char_class_t cls_reg;
    logic        last_reg;
    logic        in_vld_reg, in_vld_next;
    logic        res_vld_reg, res_vld_next;
    result_t     res_reg;
    result_t     core_res;
    logic        advance;
    logic        accept;

    ssdfa_classify u_classify (
        .byte_in (char_ch.byte_in),
        .cls     (cls_dec)
    );

    ssdfa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cls   (cls_reg),
        .last  (last_reg),
        .res   (core_res)
    );

    // a last byte needs a free result register to move on
    assign advance = in_vld_reg && (!last_reg || !res_vld_reg || result_ch.ready);
    assign char_ch.ready = !in_vld_reg || advance;
    assign accept = char_ch.valid && char_ch.ready;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (advance && last_reg)
        begin
            res_vld_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_vld_next = 1'b0;
        end
        else
        begin
            res_vld_next = res_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg  <= cls_dec;
            last_reg <= char_ch.last;
        end
        if (advance && last_reg)
        begin
            res_reg <= core_res;
        end
    end

    assign result_ch.valid       = res_vld_reg;
    assign result_ch.verdict     = res_reg.verdict;
    assign result_ch.final_state = res_reg.final_state;

    `SSDFA_ASSERT_NEXT(a_last_gives_result, advance && last_reg, res_vld_reg,
        "last byte stepped but no result offered")
    `SSDFA_ASSERT_NEXT(a_input_held, in_vld_reg && !advance, in_vld_reg,
        "stalled input register lost its byte")
    `SSDFA_ASSERT_NOW(a_ok_final_state, res_vld_reg && res_reg.verdict == VERDICT_OK,
        res_reg.final_state == ST_WORD || res_reg.final_state == ST_SPACE,
        "accept verdict with a non-accepting final state")
    `SSDFA_ASSERT_NOW(a_heredoc_final_state,
        res_vld_reg && res_reg.verdict == VERDICT_HEREDOC,
        res_reg.final_state != ST_HEREDOC && res_reg.final_state != ST_ERR,
        "here-document verdict with a bad final state")

endmodule
